[hw/rtl/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation codes, word types and controller/datapath links.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OperandWidth = 16;
	localparam int NumBits      = 33;
	localparam int DenBits      = 32;
	localparam int MagBits      = OperandWidth + 1;
	localparam int CntBits      = $clog2(MagBits + 1);
	localparam int ArithBits    = NumBits + 1;

	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_SIMP = 2'd2;

	typedef struct packed {
		logic [1:0]                     op;
		logic signed [OperandWidth-1:0] a_num;
		logic signed [OperandWidth-1:0] a_den;
		logic signed [OperandWidth-1:0] b_num;
		logic signed [OperandWidth-1:0] b_den;
	} in_word_t;

	typedef struct packed {
		logic signed [NumBits-1:0] res_num;
		logic signed [DenBits-1:0] res_den;
		logic                      status;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture operands
		logic gcd_init;  // load gcd pair (0: a_den/b_den, 1: a_num/a_den)
		logic gcd_sel;
		logic mod_init;  // start x % y
		logic mod_step;  // one restoring division step
		logic mod_done;  // x <= y, y <= remainder
		logic div_init;  // start quotient divide by gcd (0: first, 1: second)
		logic div_sel;
		logic div_step;
		logic div_save;  // store quotient (div_slot picks slot)
		logic div_slot;
		logic fin;       // compute final result into output register
	} rau_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       zero_den;
		logic       same_den;
		logic       y_zero;
	} rau_sts_t;

endpackage

[hw/rtl/rau_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand registers, Euclid gcd via bit-serial remainder, quotient unit and
// the result multiplier/adder.
// ----------------------------------------------------------------------------
module rau_datapath import rau_pkg::*; (
	input  logic      clk,
	input  in_word_t  din,
	input  rau_cmd_t  cmd,
	output rau_sts_t  sts,
	output out_word_t res
);

	in_word_t                  opr_q;
	logic [MagBits-1:0]        x_q, y_q;
	logic [MagBits-1:0]        rem_q, quo_q, dvd_q;
	logic [MagBits-1:0]        q0_q, q1_q;
	logic [MagBits-1:0]        m_an, m_ad, m_bd;
	logic [MagBits:0]          trial;
	logic [MagBits-1:0]        dvsr;
	logic [MagBits-1:0]        div_src;
	logic signed [ArithBits-1:0] an, ad, bn, bd, sa, sb, ta, tb, rn, rd;

	function automatic logic [MagBits-1:0] magn(input logic signed [OperandWidth-1:0] v);
		logic signed [MagBits-1:0] e;
		e = MagBits'(v);
		return e[MagBits-1] ? MagBits'(-e) : e;
	endfunction

	assign m_an = magn(opr_q.a_num);
	assign m_ad = magn(opr_q.a_den);
	assign m_bd = magn(opr_q.b_den);

	// The quotient divide uses the gcd held in x; the remainder uses y.
	assign dvsr    = (cmd.div_step) ? x_q : y_q;
	assign trial   = {rem_q, dvd_q[MagBits-1]} - {1'b0, dvsr};
	assign div_src = cmd.div_sel ? ((opr_q.op == OP_ADD) ? m_ad : m_ad)
	                             : ((opr_q.op == OP_ADD) ? m_bd : m_an);

	always_ff @(posedge clk) begin
		if (cmd.load)
			opr_q <= din;
		if (cmd.gcd_init) begin
			x_q <= cmd.gcd_sel ? m_an : m_ad;
			y_q <= cmd.gcd_sel ? m_ad : m_bd;
		end
		if (cmd.mod_init || cmd.div_init) begin
			rem_q <= '0;
			dvd_q <= cmd.div_init ? div_src : x_q;
			quo_q <= '0;
		end else if (cmd.mod_step || cmd.div_step) begin
			if (!trial[MagBits])
				rem_q <= trial[MagBits-1:0];
			else
				rem_q <= {rem_q[MagBits-2:0], dvd_q[MagBits-1]};
			dvd_q <= {dvd_q[MagBits-2:0], 1'b0};
			quo_q <= {quo_q[MagBits-2:0], ~trial[MagBits]};
		end
		if (cmd.mod_done) begin
			x_q <= y_q;
			y_q <= rem_q;
		end
		if (cmd.div_save) begin
			if (cmd.div_slot)
				q1_q <= quo_q;
			else
				q0_q <= quo_q;
		end
	end

	// Final arithmetic; values are tiny enough for 17x17 products.
	always_comb begin
		an = ArithBits'(opr_q.a_num);
		ad = ArithBits'(opr_q.a_den);
		bn = ArithBits'(opr_q.b_num);
		bd = ArithBits'(opr_q.b_den);
		sa = ArithBits'(q0_q);
		sb = ArithBits'(q1_q);
		rn = '0;
		rd = '0;
		ta = '0;
		tb = '0;
		unique case (opr_q.op)
			OP_MUL: begin
				rn = an * bn;
				rd = ad * bd;
			end
			OP_ADD: begin
				if (opr_q.a_den == opr_q.b_den) begin
					rn = an + bn;
					rd = ad;
				end else begin
					ta = an * sa;
					tb = bn * sb;
					if (ad < 0) ta = -ta;
					if (bd < 0) tb = -tb;
					rn = ta + tb;
					rd = sa * ArithBits'(m_ad);
				end
			end
			default: begin
				rn = (an < 0) ? -sa : sa;
				rd = (ad < 0) ? -sb : sb;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (sts.zero_den) begin
				res <= '{res_num: '0, res_den: '0, status: 1'b1};
			end else begin
				res <= '{res_num: rn[NumBits-1:0], res_den: rd[DenBits-1:0], status: 1'b0};
			end
		end
	end

	assign sts.op       = opr_q.op;
	assign sts.zero_den = (opr_q.a_den == '0) ||
	                      ((opr_q.op == OP_MUL || opr_q.op == OP_ADD) && opr_q.b_den == '0);
	assign sts.same_den = (opr_q.a_den == opr_q.b_den);
	assign sts.y_zero   = (y_q == '0);

endmodule

[hw/rtl/rau_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences gcd, quotient divides and the final result.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  rau_sts_t sts,
	output rau_cmd_t cmd,
	output logic     busy,
	output logic     done
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_GCD  = 3'd2;
	localparam logic [2:0] S_MOD  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]         state_q;
	logic [CntBits-1:0] cnt_q;
	logic               sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			sel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_DEC;
				S_DEC: begin
					if (sts.zero_den || sts.op == OP_MUL ||
					    (sts.op == OP_ADD && sts.same_den))
						state_q <= S_FIN;
					else
						state_q <= S_GCD;
				end
				S_GCD: begin
					if (sts.y_zero) begin
						state_q <= S_DIV;
						sel_q   <= 1'b0;
						cnt_q   <= '0;
					end else begin
						state_q <= S_MOD;
						cnt_q   <= '0;
					end
				end
				S_MOD: begin
					if (cnt_q == CntBits'(MagBits)) state_q <= S_GCD;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_DIV: begin
					if (cnt_q == CntBits'(MagBits)) begin
						cnt_q <= '0;
						if (sel_q) state_q <= S_FIN;
						sel_q <= ~sel_q;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && start;
		cmd.gcd_init = (state_q == S_DEC);
		cmd.gcd_sel  = (sts.op != OP_ADD);
		cmd.mod_init = (state_q == S_GCD) && !sts.y_zero;
		cmd.mod_step = (state_q == S_MOD) && (cnt_q != CntBits'(MagBits));
		cmd.mod_done = (state_q == S_MOD) && (cnt_q == CntBits'(MagBits));
		cmd.div_sel  = sel_q;
		cmd.div_init = ((state_q == S_GCD) && sts.y_zero) ||
		               ((state_q == S_DIV) && (cnt_q == CntBits'(MagBits)) && !sel_q);
		cmd.div_step = (state_q == S_DIV) && (cnt_q != CntBits'(MagBits));
		cmd.div_save = (state_q == S_DIV) && (cnt_q == CntBits'(MagBits));
		cmd.div_slot = sel_q;
		cmd.fin      = (state_q == S_FIN);
		// The second divide is started with its own select.
		if ((state_q == S_DIV) && (cnt_q == CntBits'(MagBits)) && !sel_q)
			cmd.div_sel = 1'b1;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

endmodule

[hw/rtl/rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Multiply, add or simplify signed fractions, one result word per command.
// ----------------------------------------------------------------------------
// Channel  | Ports              | Handshake
// command  | start, busy, din   | word taken when start high and busy low
// result   | done, res          | word valid for one cycle on done
//
// Multiply, equal-denominator add and zero-denominator commands skip the gcd.
// Other ops run Euclid's gcd with a bit-serial remainder per step, then two
// quotient divides by the gcd before the final result.
// busy stays high from acceptance until done; the receiver cannot stall.
// Reset clears the controller only.
module rational_arithmetic_unit import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_word_t  din,
	output logic      busy,
	output logic      done,
	output out_word_t res
);

	rau_cmd_t cmd;
	rau_sts_t sts;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start && !busy),
		.sts(sts), .cmd(cmd), .busy(busy), .done(done)
	);

	rau_datapath u_dp (
		.clk(clk), .din(din), .cmd(cmd), .sts(sts), .res(res)
	);

endmodule

[hw/rtl/rau_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level properties of the command and result words.
// ----------------------------------------------------------------------------
module rau_checker import rau_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_word_t res
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status |-> res.res_num == '0 && res.res_den == '0)
		else $error("error word not zero");

endmodule

bind rational_arithmetic_unit rau_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .res(res)
);
